// ===== design/tctp_pkg.sv =====
// ----------------------------------------------------------------------------
// tctp_pkg
// shared command and result codes for the cooldown timer pool
// ----------------------------------------------------------------------------
package tctp_pkg;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_CHECK = 3'd1;
    localparam logic [2:0] CMD_FIND  = 3'd2;
    localparam logic [2:0] CMD_RESET = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam int TYPE_W = 32;
    localparam int DATA_W = 40;

endpackage

// ===== design/tctp_ram.sv =====
// ----------------------------------------------------------------------------
// tctp_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module tctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/typed_cooldown_timer_pool.sv =====
// ----------------------------------------------------------------------------
// typed_cooldown_timer_pool
// pool of typed cooldown timers driven by a command stream
// ----------------------------------------------------------------------------
// Commands arrive one transaction at a time on the s_axis side; results leave
// on m_axis. Timer records live in one ram (one row per slot) with a
// registered read, and a per-slot valid bit cleared by reset and by clear, so
// an unwritten row reads as an unused slot. Add, check, find, reset and tick
// walk the rows in index order: one row read is issued per cycle unless an
// event stall holds the walk, and the row comes back in the next cycle, where
// it is inspected and, when needed, rewritten. With the output ready, a
// command issues the first read, takes the returned rows, loads the reply,
// hands it over and returns to idle to accept the next one. Tick events leave
// on the fly and cost nothing extra; only a cycle in which an event is still
// held by the output stalls the walk. Add, check and find run a first pass to
// locate the first matching slot; add runs a second pass to find a free row
// unless it is rejected. Clear and unknown codes skip the walk, since clear
// only drops the valid bits. Only one command is in flight; the input is
// ready again in the cycle after the final result is taken.
module typed_cooldown_timer_pool #(
    parameter int SLOTS         = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], timer_type[34:3], duration[50:35], recycled[51],
    // has_end_hook[52], has_step_hook[53], zero fill to 56
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot[3:0], event_type[35:4], ok[36], zero fill to 40
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);
    import tctp_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = DURATION_BITS;
    // row: type, duration, elapsed, complete, recycled, end hook, step hook
    localparam int ROW_W = TYPE_W + 2 * DW + 4;
    localparam logic [AW:0] LAST_IDX = (AW+1)'(SLOTS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] ttype;
        logic [DW-1:0]     dur;
        logic [DW-1:0]     ela;
        logic              comp;
        logic              rec;
        logic              endh;
        logic              steph;
    } row_t;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        cmd_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [DW-1:0]     dur_reg;
    logic              rec_reg, endh_reg, steph_reg;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [AW:0]       ridx_reg, ridx_next;        // issued read index
    logic [AW-1:0]     pidx_reg;                   // index of returned row
    logic              pval_reg, pval_next;        // returned row valid
    logic              hit_reg, hit_next;          // first match found
    logic              hcomp_reg, hcomp_next;
    logic [AW-1:0]     hidx_reg, hidx_next;

    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg, okind_next;
    logic [AW-1:0]     oslot_reg, oslot_next;
    logic [TYPE_W-1:0] otype_reg, otype_next;
    logic              ook_reg, ook_next, olast_reg, olast_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    row_t              wrow, rrow;
    logic [ROW_W-1:0]  rdata;

    logic out_free;
    logic hold_row;
    logic row_used, row_match, row_free;
    assign out_free  = !ov_reg || m_axis_tready;
    // event stall: the returned row waits until the output frees
    assign hold_row  = pval_reg && cmd_reg == CMD_TICK && !out_free;
    assign row_used  = used_reg[pidx_reg];
    assign row_match = row_used && rrow.ttype == type_reg;
    assign row_free  = !row_used || rrow.ttype == '0;

    assign rrow = row_t'(rdata);
    // a held row is re-read at its own address
    assign raddr = hold_row ? pidx_reg : ridx_reg[AW-1:0];

    tctp_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (ROW_W'(wrow)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        ridx_next  = ridx_reg;
        pval_next  = 1'b0;
        hit_next   = hit_reg;
        hcomp_next = hcomp_reg;
        hidx_next  = hidx_reg;
        ov_next    = ov_reg && !m_axis_tready;
        okind_next = okind_reg;
        oslot_next = oslot_reg;
        otype_next = otype_reg;
        ook_next   = ook_reg;
        olast_next = olast_reg;
        we         = 1'b0;
        waddr      = pidx_reg;
        wrow       = rrow;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ridx_next  = '0;
                    hit_next   = 1'b0;
                    hcomp_next = 1'b0;
                    hidx_next  = '0;
                    if (s_axis_tdata[2:0] == CMD_CLEAR)
                    begin
                        used_next  = '0;
                        state_next = ST_OUT;
                    end
                    else if (s_axis_tdata[2:0] > CMD_CLEAR)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN, ST_FILL:
            begin
                // event stall: hold the row until the output frees
                if (hold_row)
                begin
                    pval_next = 1'b1;
                end
                else
                begin
                    if (ridx_reg <= LAST_IDX)
                    begin
                        pval_next = 1'b1;
                        ridx_next = ridx_reg + 1'b1;
                    end
                    if (pval_reg)
                    begin
                        if (state_reg == ST_FILL)
                        begin
                            if (row_free && !hit_reg)
                            begin
                                hit_next            = 1'b1;
                                hidx_next           = pidx_reg;
                                we                  = 1'b1;
                                wrow.ttype          = type_reg;
                                wrow.dur            = dur_reg;
                                wrow.ela            = '0;
                                wrow.comp           = 1'b0;
                                wrow.rec            = rec_reg;
                                wrow.endh           = endh_reg;
                                wrow.steph          = steph_reg;
                                used_next[pidx_reg] = 1'b1;
                            end
                        end
                        else if (cmd_reg == CMD_RESET)
                        begin
                            if (row_match)
                            begin
                                we        = 1'b1;
                                wrow.comp = 1'b0;
                                wrow.ela  = '0;
                            end
                        end
                        else if (cmd_reg == CMD_TICK)
                        begin
                            if (row_used && rrow.ttype != '0)
                            begin
                                if (rrow.comp && !rrow.rec)
                                begin
                                    used_next[pidx_reg] = 1'b0;
                                end
                                else if (rrow.ela >= rrow.dur)
                                begin
                                    we        = 1'b1;
                                    wrow.comp = 1'b1;
                                    wrow.ela  = '0;
                                    if (rrow.endh)
                                    begin
                                        ov_next    = 1'b1;
                                        okind_next = KIND_END;
                                        oslot_next = pidx_reg;
                                        otype_next = rrow.ttype;
                                        ook_next   = 1'b0;
                                        olast_next = 1'b0;
                                    end
                                end
                                else if (!rrow.comp)
                                begin
                                    we       = 1'b1;
                                    wrow.ela = rrow.ela + 1'b1;
                                    if (rrow.steph)
                                    begin
                                        ov_next    = 1'b1;
                                        okind_next = KIND_STEP;
                                        oslot_next = pidx_reg;
                                        otype_next = rrow.ttype;
                                        ook_next   = 1'b0;
                                        olast_next = 1'b0;
                                    end
                                end
                            end
                        end
                        else if (row_match && !hit_reg)
                        begin
                            hit_next   = 1'b1;
                            hcomp_next = rrow.comp;
                            hidx_next  = pidx_reg;
                        end
                    end
                    if (!pval_next)
                    begin
                        // pass finished
                        if (state_reg == ST_SCAN && cmd_reg == CMD_ADD &&
                            !(hit_next && !hcomp_next))
                        begin
                            state_next = ST_FILL;
                            ridx_next  = '0;
                            hit_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                            // a running timer of this type rejects the add
                            if (state_reg == ST_SCAN && cmd_reg == CMD_ADD)
                            begin
                                hit_next = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b1;
                    ook_next   = 1'b0;
                    oslot_next = '0;
                    okind_next = KIND_REPLY;
                    otype_next = type_reg;
                    unique case (cmd_reg)
                        CMD_TICK:
                        begin
                            okind_next = KIND_DONE;
                            otype_next = '0;
                        end
                        CMD_ADD:
                        begin
                            ook_next   = hit_reg;
                            oslot_next = hit_reg ? hidx_reg : '0;
                        end
                        CMD_CHECK:
                        begin
                            ook_next   = hit_reg && !hcomp_reg;
                            oslot_next = hit_reg ? hidx_reg : '0;
                        end
                        CMD_FIND:
                        begin
                            ook_next   = hit_reg;
                            oslot_next = hit_reg ? hidx_reg : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!ov_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            ridx_reg  <= '0;
            pval_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            hcomp_reg <= 1'b0;
            hidx_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ridx_reg  <= ridx_next;
            pval_reg  <= pval_next;
            hit_reg   <= hit_next;
            hcomp_reg <= hcomp_next;
            hidx_reg  <= hidx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            cmd_reg   <= s_axis_tdata[2:0];
            type_reg  <= s_axis_tdata[34:3];
            dur_reg   <= DW'(s_axis_tdata[50:35] & 16'((33'd1 << DW) - 33'd1));
            rec_reg   <= s_axis_tdata[51];
            endh_reg  <= s_axis_tdata[52];
            steph_reg <= s_axis_tdata[53];
        end
        // a held row is re-read at the same address, so keep the index stable
        if (!hold_row)
        begin
            pidx_reg <= ridx_reg[AW-1:0];
        end
        okind_reg <= okind_next;
        oslot_reg <= oslot_next;
        otype_reg <= otype_next;
        ook_reg   <= ook_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = DATA_W'({ook_reg, otype_reg, 4'(oslot_reg)});

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ov_reg)
        else $error("input taken while a result is pending");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && m_axis_tready && olast_reg) |=> state_reg == ST_IDLE)
        else $error("final result did not end the command");
    a_event_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !olast_reg) |-> (okind_reg == KIND_END || okind_reg == KIND_STEP))
        else $error("non-final result is not a timer event");
`endif
endmodule
